// ----- sv/gcode_line_prefilter_defines.svh -----
// Assertion macros used by the G-code line prefilter top level.
`ifndef GCODE_LINE_PREFILTER_DEFINES_SVH
`define GCODE_LINE_PREFILTER_DEFINES_SVH

// Same-cycle implication, clocked on clk_i and disabled while rst_ni is low
`define GLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and disabled while rst_ni is low
`define GLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/glp_pkg.sv -----
// Types and constants of the G-code line prefilter.
`default_nettype none

package glp_pkg;

  // Characters recognised by the filter
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7a;
  localparam logic [7:0] CH_IDLE   = 8'hff;
  localparam logic [7:0] CASE_OFS  = 8'h20;

  // Result kinds
  localparam logic [1:0] KIND_EMPTY    = 2'd0;
  localparam logic [1:0] KIND_SYSTEM   = 2'd1;
  localparam logic [1:0] KIND_GCODE    = 2'd2;
  localparam logic [1:0] KIND_OVERFLOW = 2'd3;

  // Comment modes
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_PAREN = 2'd1;
  localparam logic [1:0] MODE_SEMI  = 2'd2;

  // What one received byte asks the datapath to do
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_STORE,
    ACT_EMPTY,
    ACT_LINE,
    ACT_OVF
  } act_e;

  typedef struct packed {
    act_e       act;
    logic       eol;
    logic [1:0] mode_d;
    logic [7:0] chr;
  } filt_t;

endpackage

`default_nettype wire

// ----- sv/gcode_line_prefilter.sv -----
// Top level of the G-code line prefilter: line store, drain sequencer and output register.
// Received bytes enter on the s_axis side one transaction at a time. A byte that is
// dropped, stored, or that yields a single result (empty line or overflow) is taken on
// its handshake; the next byte is taken in the following cycle unless a single result
// still waits behind a full output register, in which case input holds until that
// register frees. On CR or LF ending a non-empty line the input holds while the line
// is read back from the line store, one character per cycle through its registered read
// port while the output side does not stall; the next byte is taken once the drain ends.
// Each character leaves as one m_axis transaction, tlast on the final one, with the line
// kind on tuser; the kind is system command when the first character is '$' and G-code
// line otherwise.
// The line store needs no clearing pass after reset: only entries below the fill count
// are ever read.
`default_nettype none

module gcode_line_prefilter
  import glp_pkg::*;
#(
  parameter int unsigned LINE_LEN = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tdata fields, lowest bit up: rx_byte[7:0]
  input  wire logic [7:0]  s_axis_tdata_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tdata fields, lowest bit up: line_char[7:0]
  output logic [7:0]       m_axis_tdata_o,
  // tuser fields, lowest bit up: line_kind[1:0]
  output logic [1:0]       m_axis_tuser_o,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // tlast: last
  output logic             m_axis_tlast_o
);

`include "gcode_line_prefilter_defines.svh"

  localparam int unsigned CW = $clog2(LINE_LEN);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_HOLD  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [1:0]    mode_q;
  logic [CW-1:0] cnt_q;
  logic          flushed_q;
  logic          first_sys_q;

  logic [CW-1:0] drain_cnt_q;
  logic [CW-1:0] rd_addr_q;
  logic [CW-1:0] rd_idx_q;
  logic          rd_vld_q;
  logic [1:0]    line_kind_q;
  logic [1:0]    pend_kind_q;

  logic          out_vld_q;
  logic [7:0]    out_char_q;
  logic [1:0]    out_kind_q;
  logic          out_last_q;

  filt_t         filt;
  logic          in_acc;
  logic          out_free;
  logic          single_res;
  logic          issue_left;
  logic          rd_issue;
  logic          take_rd;
  logic          ram_we;
  logic [7:0]    ram_rdata;

  // Classify the incoming byte against the current line state
  glp_filter #(
    .LINE_LEN (LINE_LEN)
  ) u_filter (
    .byte_i    (s_axis_tdata_i),
    .mode_i    (mode_q),
    .count_i   (cnt_q),
    .flushed_i (flushed_q),
    .filt_o    (filt)
  );

  // Line store
  glp_ram #(
    .WIDTH (8),
    .DEPTH (LINE_LEN)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q),
    .wdata_i (filt.chr),
    .re_i    (rd_issue),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign single_res      = in_acc && ((filt.act == ACT_EMPTY) || (filt.act == ACT_OVF));
  assign ram_we          = in_acc && (filt.act == ACT_STORE);

  // Drain pipeline: one read in flight, next read only when its slot frees
  assign issue_left = (rd_addr_q != drain_cnt_q);
  assign take_rd    = (state_q == ST_DRAIN) && rd_vld_q && out_free;
  assign rd_issue   = (state_q == ST_DRAIN) && issue_left && (!rd_vld_q || take_rd);

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (filt.act == ACT_LINE)) begin
          state_d = ST_DRAIN;
        end else if (single_res && !out_free) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (!issue_left && (!rd_vld_q || take_rd)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Update line state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_NONE;
      cnt_q     <= '0;
      flushed_q <= 1'b0;
    end else if (in_acc) begin
      mode_q <= filt.mode_d;
      if (filt.eol) begin
        cnt_q     <= '0;
        flushed_q <= 1'b0;
      end else if (filt.act == ACT_OVF) begin
        cnt_q     <= '0;
        flushed_q <= 1'b1;
      end else if (filt.act == ACT_STORE) begin
        cnt_q     <= cnt_q + 1'b1;
        flushed_q <= 1'b0;
      end
    end
  end

  // Remember whether the line opens with '$'
  always_ff @(posedge clk_i) begin
    if (ram_we && (cnt_q == '0)) begin
      first_sys_q <= (filt.chr == CH_DOLLAR);
    end
  end

  // Latch drain length, kind, pending single result and read index
  always_ff @(posedge clk_i) begin
    if (in_acc && (filt.act == ACT_LINE)) begin
      drain_cnt_q <= cnt_q;
      line_kind_q <= first_sys_q ? KIND_SYSTEM : KIND_GCODE;
    end
    if (single_res) begin
      pend_kind_q <= (filt.act == ACT_OVF) ? KIND_OVERFLOW : KIND_EMPTY;
    end
    if (rd_issue) begin
      rd_idx_q <= rd_addr_q;
    end
  end

  // Read address and read-data valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (in_acc && (filt.act == ACT_LINE)) begin
        rd_addr_q <= '0;
      end else if (rd_issue) begin
        rd_addr_q <= rd_addr_q + 1'b1;
      end
      if (rd_issue) begin
        rd_vld_q <= 1'b1;
      end else if (take_rd) begin
        rd_vld_q <= 1'b0;
      end
    end
  end

  // Output register: valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (take_rd || (single_res && out_free) ||
                 ((state_q == ST_HOLD) && out_free)) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk_i) begin
    if (take_rd) begin
      out_char_q <= ram_rdata;
      out_kind_q <= line_kind_q;
      out_last_q <= (rd_idx_q == (drain_cnt_q - 1'b1));
    end else if (single_res && out_free) begin
      out_char_q <= 8'h00;
      out_kind_q <= (filt.act == ACT_OVF) ? KIND_OVERFLOW : KIND_EMPTY;
      out_last_q <= 1'b1;
    end else if ((state_q == ST_HOLD) && out_free) begin
      out_char_q <= 8'h00;
      out_kind_q <= pend_kind_q;
      out_last_q <= 1'b1;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_char_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  // Checks
  `GLP_ASSERT_IMP(a_no_write_in_drain, ram_we, !rd_issue && (state_q == ST_IDLE), "line store written while draining")
  `GLP_ASSERT_IMP(a_read_in_range, rd_issue, rd_addr_q < drain_cnt_q, "line store read beyond fill count")
  `GLP_ASSERT_NXT(a_ovf_clears, in_acc && (filt.act == ACT_OVF), (cnt_q == '0) && flushed_q, "overflow did not flush the line")
  `GLP_ASSERT_NXT(a_last_ends_drain, take_rd && (rd_idx_q == (drain_cnt_q - 1'b1)), state_q == ST_IDLE, "drain did not end after final character")

endmodule

`default_nettype wire

// ----- sv/glp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module glp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- sv/glp_filter.sv -----
// Byte classifier: comment tracking, dropping, case folding and overflow check.
`default_nettype none

module glp_filter
  import glp_pkg::*;
#(
  parameter int unsigned LINE_LEN = 64
) (
  input  wire logic [7:0]                  byte_i,
  input  wire logic [1:0]                  mode_i,
  input  wire logic [$clog2(LINE_LEN)-1:0] count_i,
  input  wire logic                        flushed_i,
  output filt_t                            filt_o
);

  localparam int unsigned CW = $clog2(LINE_LEN);
  localparam logic [CW-1:0] COUNT_MAX = CW'(LINE_LEN - 1);

  logic is_eol;
  logic is_lower;

  assign is_eol   = (byte_i == CH_LF) || (byte_i == CH_CR);
  assign is_lower = (byte_i >= CH_LOW_A) && (byte_i <= CH_LOW_Z);

  // Decide the action for one byte
  always_comb begin
    filt_o.act    = ACT_NONE;
    filt_o.eol    = 1'b0;
    filt_o.mode_d = mode_i;
    filt_o.chr    = is_lower ? (byte_i - CASE_OFS) : byte_i;
    if (byte_i == CH_IDLE) begin
      filt_o.act = ACT_NONE;
    end else if (is_eol) begin
      filt_o.eol    = 1'b1;
      filt_o.mode_d = MODE_NONE;
      if (count_i != '0) begin
        filt_o.act = ACT_LINE;
      end else if (!flushed_i) begin
        filt_o.act = ACT_EMPTY;
      end
    end else if (mode_i != MODE_NONE) begin
      // inside a comment only ')' can end a parenthesis comment
      if ((byte_i == CH_RPAREN) && (mode_i == MODE_PAREN)) begin
        filt_o.mode_d = MODE_NONE;
      end
    end else if ((byte_i <= CH_SPACE) || (byte_i == CH_SLASH)) begin
      filt_o.act = ACT_NONE;
    end else if (byte_i == CH_LPAREN) begin
      filt_o.mode_d = MODE_PAREN;
    end else if (byte_i == CH_SEMI) begin
      filt_o.mode_d = MODE_SEMI;
    end else if (count_i >= COUNT_MAX) begin
      filt_o.act    = ACT_OVF;
      filt_o.mode_d = MODE_NONE;
    end else begin
      filt_o.act = ACT_STORE;
    end
  end

endmodule

`default_nettype wire

// ----- test/gcode_line_prefilter_checker.sv -----
// Checker for the G-code line prefilter: predicts line output and compares it per transaction.
`default_nettype none

module gcode_line_prefilter_checker
  import glp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  s_axis_tdata_i,
  input  wire logic        s_axis_tvalid_i,
  input  wire logic        s_axis_tready_i,
  input  wire logic [7:0]  m_axis_tdata_i,
  input  wire logic [1:0]  m_axis_tuser_i,
  input  wire logic        m_axis_tvalid_i,
  input  wire logic        m_axis_tready_i,
  input  wire logic        m_axis_tlast_i,
  output int               fail_count_o,
  output int               pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_LEN   = 64;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [7:0] chr;
    logic [1:0] kind;
    logic       is_last;
  } line_out_t;

  // Filter state mirrored from the block
  logic [1:0]  cmt_mode;
  int unsigned fill;
  logic [7:0]  line_buf [LINE_LEN];
  bit          flushed;

  line_out_t   line_out_q [$];

  task automatic expect_out(input logic [7:0] chr, input logic [1:0] kind, input logic fin);
    line_out_q.push_back('{chr: chr, kind: kind, is_last: fin});
  endtask

  // Advance the filter by one received byte and queue the line output it causes
  task automatic filter_byte(input logic [7:0] rx);
    logic [7:0] chr;
    logic [1:0] kind;
    chr = rx;
    if (chr == CH_IDLE) return;

    // End of line: emit the line, an empty-line marker, or nothing after a flush
    if (chr == CH_LF || chr == CH_CR) begin
      if (fill == 0) begin
        if (!flushed) expect_out(8'h00, KIND_EMPTY, 1'b1);
      end else begin
        kind = (line_buf[0] == CH_DOLLAR) ? KIND_SYSTEM : KIND_GCODE;
        for (int i = 0; i < int'(fill); i++)
          expect_out(line_buf[i], kind, i == int'(fill) - 1);
      end
      fill     = 0;
      cmt_mode = MODE_NONE;
      flushed  = 1'b0;
      return;
    end

    // Drop everything inside a comment; only ')' closes the parenthesis kind
    if (cmt_mode != MODE_NONE) begin
      if (chr == CH_RPAREN && cmt_mode == MODE_PAREN) cmt_mode = MODE_NONE;
      return;
    end

    if (chr <= CH_SPACE || chr == CH_SLASH) return;
    if (chr == CH_LPAREN) begin
      cmt_mode = MODE_PAREN;
      return;
    end
    if (chr == CH_SEMI) begin
      cmt_mode = MODE_SEMI;
      return;
    end

    // Store full: discard the line and flag the overflow
    if (fill >= LINE_LEN - 1) begin
      expect_out(8'h00, KIND_OVERFLOW, 1'b1);
      fill     = 0;
      cmt_mode = MODE_NONE;
      flushed  = 1'b1;
      return;
    end

    if (chr >= CH_LOW_A && chr <= CH_LOW_Z) chr = chr - CASE_OFS;
    line_buf[fill] = chr;
    fill++;
    flushed = 1'b0;
  endtask

  // Compare one output transaction with the oldest queued line output
  task automatic check_out();
    line_out_t want;
    line_out_t got;
    got = '{chr: m_axis_tdata_i, kind: m_axis_tuser_i, is_last: m_axis_tlast_i};
    if (line_out_q.size() == 0) begin
      if (fail_count_o < REPORT_MAX)
        $display("%0t: unexpected output: char %h kind %0d last %b",
                 $realtime, got.chr, got.kind, got.is_last);
      fail_count_o++;
    end else begin
      want = line_out_q.pop_front();
      if (got.chr !== want.chr || got.kind !== want.kind || got.is_last !== want.is_last) begin
        if (fail_count_o < REPORT_MAX)
          $display("%0t: output mismatch: expected char %h kind %0d last %b, got char %h kind %0d last %b",
                   $realtime, want.chr, want.kind, want.is_last,
                   got.chr, got.kind, got.is_last);
        fail_count_o++;
      end
    end
  endtask

  // Sample both channels on the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmt_mode     = MODE_NONE;
      fill         = 0;
      flushed      = 1'b0;
      fail_count_o = 0;
      pending_o    = 0;
      line_out_q.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_out();
      if (s_axis_tvalid_i && s_axis_tready_i) filter_byte(s_axis_tdata_i);
      pending_o = line_out_q.size();
    end
  end

endmodule

`default_nettype wire

// ----- test/gcode_line_prefilter_tb.sv -----
// Testbench top for the G-code line prefilter: clock, reset, byte stimulus and verdict.
`default_nettype none

module gcode_line_prefilter_tb
  import glp_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 330;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 200;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        m_axis_tlast;

  int fail_count;
  int pending;
  int byte_count = 0;
  int hold_reqs  = 0;
  int holds_done = 0;
  bit tx_quiet   = 1'b0;
  bit rx_quiet   = 1'b0;

  always #5 clk_i = ~clk_i;

  gcode_line_prefilter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tlast_o (m_axis_tlast)
  );

  gcode_line_prefilter_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .m_axis_tuser_i (m_axis_tuser),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tlast_i (m_axis_tlast),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Letter in either case or a digit: always stored
  function automatic logic [7:0] plain_char();
    case ($urandom_range(0, 2))
      0:       return CH_LOW_A + 8'($urandom_range(0, 25));
      1:       return CH_LOW_A - CASE_OFS + 8'($urandom_range(0, 25));
      default: return 8'h30 + 8'($urandom_range(0, 9));   // '0' to '9'
    endcase
  endfunction

  // Noise byte: any printable character, blank, idle, high or control byte
  function automatic logic [7:0] noise_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62) return 8'($urandom_range(8'h21, 8'h7e));
    if (r < 70) return CH_SPACE;
    if (r < 75) return CH_IDLE;
    if (r < 82) return 8'($urandom_range(8'h7f, 8'hfe));
    if (r < 88) return 8'($urandom_range(8'h00, 8'h1f));
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one byte after a random gap and hold it until the block takes it
  task automatic send_byte(input logic [7:0] rx);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = 8'($urandom_range(0, 255));
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = rx;
    do @(posedge clk_i); while (!s_axis_tready);
    if (rx != CH_IDLE) byte_count++;
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_byte(txt[i]);
  endtask

  // One command line: optional '$', n_tok tokens, then CR or LF
  task automatic send_line(input int n_tok, input bit plain, input bit sys);
    int r;
    int k;
    tx_quiet = ($urandom_range(0, 4) == 0);
    if (sys) send_byte(CH_DOLLAR);
    for (int i = 0; i < n_tok; i++) begin
      if (plain) begin
        send_byte(plain_char());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          send_byte(CH_LPAREN);
          k = $urandom_range(0, 5);
          repeat (k) send_byte(noise_char());
          if ($urandom_range(0, 5) != 0) send_byte(CH_RPAREN);
        end else if (r < 9) begin
          send_byte(CH_SEMI);
        end else if (r < 50) begin
          send_byte(plain_char());
        end else begin
          send_byte(noise_char());
        end
      end
    end
    send_byte(($urandom_range(0, 1) != 0) ? CH_LF : CH_CR);
  endtask

  // Receiver: random ready pattern, with a long hold-off on request
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (holds_done != hold_reqs) begin
        holds_done++;
        m_axis_tready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
        if ($urandom_range(0, 9) == 0) rx_quiet = ~rx_quiet;
        repeat ($urandom_range(0, 8)) @(negedge clk_i);
        gap = rx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
          @(negedge clk_i);
          m_axis_tready = 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int r;
    int line_no;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty line, case folding, system command, both comment kinds,
    // idle inside a comment, dropped bytes, high bytes and the letter range edges
    send_byte(CH_LF);
    send_text("g1 x9\n");
    send_text("$h\r");
    send_byte(CH_LPAREN);
    send_byte(CH_IDLE);
    send_text("a)B;c)\n");
    send_byte(8'h00);
    send_byte(CH_SPACE);
    send_byte(CH_SLASH);
    send_byte(CH_IDLE);
    send_byte(8'h7f);
    send_byte(8'hfe);
    send_text("`{az");
    send_byte(CH_LF);

    // Fill the store exactly, then overflow and end the flushed line at once
    send_line(62, 1'b1, 1'b1);
    send_line(64, 1'b1, 1'b0);

    // Random lines, mostly short, a few near or past the store size
    line_no = 0;
    while (byte_count < ITEM_TARGET) begin
      if (line_no == 1 || line_no == 12) hold_reqs++;
      r = $urandom_range(0, 99);
      if (r < 78)
        send_line($urandom_range(0, 10), 1'b0, $urandom_range(0, 3) == 0);
      else if (r < 92)
        send_line($urandom_range(11, 30), 1'b0, $urandom_range(0, 3) == 0);
      else if (r < 96)
        send_line($urandom_range(55, 62), 1'b1, $urandom_range(0, 3) == 0);
      else
        send_line($urandom_range(63, 70), 1'b1, $urandom_range(0, 3) == 0);
      line_no++;
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
